### src/rhsl_pkg.sv
// types, constants and the divider step for the rgb to hue, saturation and luma pipeline
// no dependencies; used by every module in src
`default_nettype none

package rhsl_pkg;

  localparam int unsigned HUE_SIXTH      = 3840;
  localparam int unsigned HUE_FULL       = 23040;
  localparam int unsigned DIV_BITS       = 16;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [17:0] luma_weighted;
    logic [14:0] hue_q6;
    logic [15:0] saturation_q16;
  } result_t;

  // remainder, then numerator bits still to come shifting out as quotient bits shift in
  typedef struct packed {
    logic [7:0]          divisor;
    logic [7:0]          rem;
    logic [DIV_BITS-1:0] sh;
  } div_t;

  typedef struct packed {
    logic [17:0] luma;
    logic [14:0] base;
    logic        neg;
    logic        grey;
    logic        black;
    div_t        hue_div;
    div_t        sat_div;
  } work_t;

  function automatic div_t div_step(input div_t cur);
    div_t       nxt;
    logic [8:0] trial;
    logic       qbit;
    trial = {cur.rem, cur.sh[DIV_BITS-1]};
    qbit  = (trial >= {1'b0, cur.divisor});
    nxt.divisor = cur.divisor;
    nxt.rem     = qbit ? 8'(trial - {1'b0, cur.divisor}) : trial[7:0];
    nxt.sh      = {cur.sh[DIV_BITS-2:0], qbit};
    return nxt;
  endfunction

endpackage

`default_nettype wire

### src/rhsl_front.sv
// first stage: max, min, sector, luma and the two division numerators
// depends on rhsl_pkg
`default_nettype none

module rhsl_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  rhsl_pkg::pixel_t in_item,
  output logic             in_stall,
  output logic             out_valid,
  output rhsl_pkg::work_t  out_item,
  input  wire              out_stall
);

  rhsl_pkg::work_t item_next;
  logic [7:0]      mx;
  logic [7:0]      mn;
  logic [7:0]      delta;
  logic [7:0]      op_a;
  logic [7:0]      op_b;
  logic [7:0]      mag;
  logic            neg;
  logic [14:0]     base;
  logic [23:0]     hue_num;
  logic [23:0]     sat_num;
  logic            advance;

  always_comb begin
    mx = in_item.red;
    mn = in_item.red;
    if (in_item.green > mx) mx = in_item.green;
    if (in_item.blue > mx) mx = in_item.blue;
    if (in_item.green < mn) mn = in_item.green;
    if (in_item.blue < mn) mn = in_item.blue;
    delta = mx - mn;

    // red first, then green on ties
    if (mx == in_item.red) begin
      op_a = in_item.green;
      op_b = in_item.blue;
      base = 15'd0;
    end else if (mx == in_item.green) begin
      op_a = in_item.blue;
      op_b = in_item.red;
      base = 15'(2 * rhsl_pkg::HUE_SIXTH);
    end else begin
      op_a = in_item.red;
      op_b = in_item.green;
      base = 15'(4 * rhsl_pkg::HUE_SIXTH);
    end
    neg = (op_a < op_b);
    mag = neg ? (op_b - op_a) : (op_a - op_b);
    // negative red hue wraps round the full circle
    if (neg && (base == 15'd0)) base = 15'(rhsl_pkg::HUE_FULL);

    hue_num = ({16'd0, mag} << 12) - ({16'd0, mag} << 8);
    sat_num = {delta, 16'd0} - {16'd0, delta};

    item_next.luma = 18'(in_item.red) * 18'd299 + 18'(in_item.green) * 18'd587
                   + 18'(in_item.blue) * 18'd114;
    item_next.base  = base;
    item_next.neg   = neg;
    item_next.grey  = (delta == 8'd0);
    item_next.black = (mx == 8'd0);
    item_next.hue_div.divisor = delta;
    item_next.hue_div.rem     = hue_num[23:16];
    item_next.hue_div.sh      = hue_num[15:0];
    item_next.sat_div.divisor = mx;
    item_next.sat_div.rem     = sat_num[23:16];
    item_next.sat_div.sh      = sat_num[15:0];
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

### src/rhsl_div_stage.sv
// one divider stage: BITS_PER_STAGE (4) quotient bits of both the hue and saturation divisions
// depends on rhsl_pkg
`default_nettype none

module rhsl_div_stage (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  rhsl_pkg::work_t in_item,
  output logic            in_stall,
  output logic            out_valid,
  output rhsl_pkg::work_t out_item,
  input  wire             out_stall
);

  rhsl_pkg::work_t item_next;
  logic            advance;

  always_comb begin
    item_next = in_item;
    for (int i = 0; i < rhsl_pkg::BITS_PER_STAGE; i++) begin
      item_next.hue_div = rhsl_pkg::div_step(item_next.hue_div);
      item_next.sat_div = rhsl_pkg::div_step(item_next.sat_div);
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

### src/rhsl_back.sv
// last stage: floor or ceiling of the hue quotient, sector offset, grey and black cases
// depends on rhsl_pkg
`default_nettype none

module rhsl_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  rhsl_pkg::work_t   in_item,
  output logic              in_stall,
  output logic              out_valid,
  output rhsl_pkg::result_t out_item,
  input  wire               out_stall
);

  rhsl_pkg::result_t item_next;
  logic [14:0]       quo;
  logic [14:0]       ceil_q;
  logic              advance;

  always_comb begin
    quo    = in_item.hue_div.sh[14:0];
    ceil_q = quo + 15'(in_item.hue_div.rem != 8'd0);
    item_next.luma_weighted = in_item.luma;
    if (in_item.grey) begin
      item_next.hue_q6 = 15'd0;
    end else if (in_item.neg) begin
      item_next.hue_q6 = in_item.base - ceil_q;
    end else begin
      item_next.hue_q6 = in_item.base + quo;
    end
    item_next.saturation_q16 = in_item.black ? 16'd0 : in_item.sat_div.sh;
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

### src/rgb_to_hue_saturation_luma.sv
// rgb pixel to luma, hue and saturation sort keys
// an accepted pixel passes through registered stages in order: front, 4 divider stages, back
// throughput: one item per cycle while the output is not stalled; the dividers are restoring, 4 bits per stage
// a stalled stage only holds back the stages behind it; bubbles close up
// reset clears the valid bits of every stage; payload registers are not reset
`default_nettype none

module rgb_to_hue_saturation_luma (
  input  wire                clk,
  input  wire                rst,
  input  wire                pixel_valid,
  input  rhsl_pkg::pixel_t   pixel,
  output logic               pixel_stall,
  output logic               result_valid,
  output rhsl_pkg::result_t  result,
  input  wire                result_stall
);

  localparam int unsigned N = rhsl_pkg::DIV_STAGES;

  rhsl_pkg::work_t stage_item  [N+1];
  logic            stage_valid [N+1];
  logic            stage_stall [N+1];

  rhsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_item   (pixel),
    .in_stall  (pixel_stall),
    .out_valid (stage_valid[0]),
    .out_item  (stage_item[0]),
    .out_stall (stage_stall[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_div
    rhsl_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_item   (stage_item[k]),
      .in_stall  (stage_stall[k]),
      .out_valid (stage_valid[k+1]),
      .out_item  (stage_item[k+1]),
      .out_stall (stage_stall[k+1])
    );
  end

  rhsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[N]),
    .in_item   (stage_item[N]),
    .in_stall  (stage_stall[N]),
    .out_valid (result_valid),
    .out_item  (result),
    .out_stall (result_stall)
  );

endmodule

`default_nettype wire

### sim/rgb_to_hue_saturation_luma_tb.sv
// testbench for rgb_to_hue_saturation_luma: directed and random pixels checked against
// a sort key predictor, with random idling on both channels and a long output hold-off
// depends on rhsl_pkg and rgb_to_hue_saturation_luma from src
`timescale 1ns / 100ps

module rgb_to_hue_saturation_luma_tb;

  localparam int SIXTH_Q6   = int'(rhsl_pkg::HUE_SIXTH);
  localparam int FULL_Q6    = int'(rhsl_pkg::HUE_FULL);
  localparam int SAT_FULL   = 65535;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 80;
  localparam int MAX_SHOWN  = 40;

  logic              clk;
  logic              rst          = 1'b1;
  logic              pixel_valid  = 1'b0;
  rhsl_pkg::pixel_t  pixel        = '0;
  logic              pixel_stall;
  logic              result_valid;
  rhsl_pkg::result_t result;
  logic              result_stall = 1'b0;

  bit src_idling  = 1'b1;
  bit sink_idling = 1'b1;
  bit hold_req    = 1'b0;
  int idle_cycles = 0;

  function automatic rhsl_pkg::result_t sort_keys_of(input rhsl_pkg::pixel_t p);
    rhsl_pkg::result_t k;
    int      r, g, b, hi, lo, span, num, hue;
    r    = int'(p.red);
    g    = int'(p.green);
    b    = int'(p.blue);
    hi   = r;
    lo   = r;
    hue  = 0;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    if (span != 0) begin
      if (hi == r) begin
        num = SIXTH_Q6 * (g - b);
      end else if (hi == g) begin
        num = SIXTH_Q6 * (b - r) + 2 * SIXTH_Q6 * span;
      end else begin
        num = SIXTH_Q6 * (r - g) + 4 * SIXTH_Q6 * span;
      end
      hue = (num >= 0) ? num / span : -((-num + span - 1) / span);
      if (hue < 0) hue += FULL_Q6;
    end
    k.luma_weighted  = 18'(299 * r + 587 * g + 114 * b);
    k.hue_q6         = 15'(hue);
    k.saturation_q16 = (hi == 0) ? 16'd0 : 16'((SAT_FULL * span) / hi);
    return k;
  endfunction

  class sort_key_board;
    rhsl_pkg::result_t expected_keys[$];
    int      mismatches = 0;

    task report_mismatch(input string msg);
      if (mismatches < MAX_SHOWN) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function int pending();
      return expected_keys.size();
    endfunction

    task note_pixel(input rhsl_pkg::pixel_t p);
      expected_keys = {expected_keys, sort_keys_of(p)};
    endtask

    task check_keys(input rhsl_pkg::result_t got);
      rhsl_pkg::result_t want;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("result with no item waiting, luma %0d hue %0d sat %0d",
                                  got.luma_weighted, got.hue_q6, got.saturation_q16));
      end else begin
        want = expected_keys.pop_front();
        if (got.luma_weighted !== want.luma_weighted)
          report_mismatch($sformatf("luma_weighted %0d, expected %0d",
                                    got.luma_weighted, want.luma_weighted));
        if (got.hue_q6 !== want.hue_q6)
          report_mismatch($sformatf("hue_q6 %0d, expected %0d", got.hue_q6, want.hue_q6));
        if (got.saturation_q16 !== want.saturation_q16)
          report_mismatch($sformatf("saturation_q16 %0d, expected %0d",
                                    got.saturation_q16, want.saturation_q16));
      end
    endtask
  endclass

  sort_key_board board = new();

  rgb_to_hue_saturation_luma i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // item monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) board.note_pixel(pixel);
      if (result_valid && !result_stall) board.check_keys(result);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side stall
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input rhsl_pkg::pixel_t p);
    int gap;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    rhsl_pkg::pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    send_pixel(p);
  endtask

  task automatic drain;
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic rhsl_pkg::pixel_t random_pixel();
    rhsl_pkg::pixel_t p;
    logic [7:0] v, w;
    p = rhsl_pkg::pixel_t'($urandom);
    v = 8'($urandom);
    w = 8'($urandom);
    case ($urandom_range(0, 9))
      6: p = '{v, v, v};
      7: begin
        // two channels share the maximum
        if (w > v) {v, w} = {w, v};
        case ($urandom_range(0, 2))
          0:       p = '{v, v, w};
          1:       p = '{v, w, v};
          default: p = '{w, v, v};
        endcase
      end
      8: p = '{corner_byte(), corner_byte(), corner_byte()};
      9: begin
        // two channels share the minimum
        if (w < v) {v, w} = {w, v};
        case ($urandom_range(0, 2))
          0:       p = '{v, v, w};
          1:       p = '{v, w, v};
          default: p = '{w, v, v};
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // black, white, grey and the primaries
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(1, 1, 1);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    // ties on the maximum: red wins over green and blue, green over blue
    send_rgb(255, 255, 0);
    send_rgb(255, 0, 255);
    send_rgb(0, 255, 255);
    send_rgb(200, 200, 17);
    // red maximum with green below blue wraps round; then small, near-tie and mixed values
    send_rgb(255, 0, 1);
    send_rgb(255, 254, 255);
    send_rgb(2, 0, 1);
    send_rgb(1, 0, 0);
    send_rgb(0, 1, 0);
    send_rgb(0, 0, 1);
    send_rgb(254, 255, 0);
    send_rgb(0, 254, 255);
    send_rgb(255, 1, 254);
    send_rgb(255, 0, 254);
    send_rgb(170, 85, 0);
    send_rgb(85, 170, 255);

    repeat (500) send_pixel(random_pixel());

    // hold the output back while items keep coming, then let everything through
    src_idling = 1'b0;
    hold_req   = 1'b1;
    repeat (60) send_pixel(random_pixel());
    drain();
    src_idling = 1'b1;

    repeat (450) send_pixel(random_pixel());

    src_idling  = 1'b0;
    sink_idling = 1'b0;
    repeat (120) send_pixel(random_pixel());

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
src/rhsl_pkg.sv
src/rhsl_front.sv
src/rhsl_div_stage.sv
src/rhsl_back.sv
src/rgb_to_hue_saturation_luma.sv
sim/rgb_to_hue_saturation_luma_tb.sv
